@@ rtl/uvs_pkg.sv @@
// uvs_pkg: shared types and constants of the UV-sphere tessellator.
// No dependencies.
`timescale 1ns / 1ps
package uvs_pkg;

  localparam int CNT_W        = 9;   // count and index width
  localparam int IDX_W        = 17;  // vertex index width
  localparam int DIV_W        = 41;  // dividend width, index << 32 plus half divisor
  localparam int CORDIC_STEPS = 24;
  localparam int CRD_W        = 33;  // CORDIC x/y/z datapath, signed
  localparam int UNIT_W       = 16;  // Q1.14 sine/cosine
  localparam int MAX_SECTORS  = 256; // upper clamp of sector_count, fits CNT_W
  localparam int MAX_STACKS   = 256; // upper clamp of stack_count, fits CNT_W
  localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [16:0] ONE_Q14 = 17'sd16384;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SECTOR = 2'd1;
  localparam logic [1:0] REG_STACK  = 2'd2;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335086,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
  };

  // one result slot entering the pipeline
  typedef struct packed {
    logic             vld;
    logic             vtx;
    logic             last;
    logic [CNT_W-1:0] s;
    logic [CNT_W-1:0] t;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } slot_t;

  // control and triangle data riding beside the math
  typedef struct packed {
    logic             vld;
    logic             vtx;
    logic             last;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } side_t;

endpackage

@@ rtl/uvs_front.sv @@
// uvs_front: command intake, grid range checks, triangle indices, and
// the split of a two-triangle query into two slots. Uses uvs_pkg.
`timescale 1ns / 1ps
module uvs_front import uvs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             func,
  input  logic [CNT_W-1:0] stack_index,
  input  logic [CNT_W-1:0] sector_index,
  input  logic [CNT_W-1:0] nsec,
  input  logic [CNT_W-1:0] nstk,
  output slot_t            slot
);

  logic             pend;
  logic [IDX_W-1:0] pa, pb, pc;
  logic             acc;
  logic [19:0]      cur, nxt;
  logic             v_ok, t_ok, up, lo;
  slot_t            slot_next;

  assign acc  = start && !busy;
  assign busy = pend;

  assign cur  = 20'(stack_index) * 20'({1'b0, nsec} + 10'd1) + 20'(sector_index);
  assign nxt  = cur + 20'(nsec) + 20'd1;
  assign v_ok = (stack_index <= nstk) && (sector_index <= nsec);
  assign t_ok = (stack_index < nstk) && (sector_index < nsec);
  assign up   = stack_index != '0;
  assign lo   = stack_index != (nstk - 9'd1);

  always_comb begin
    slot_next     = '0;
    slot_next.s   = stack_index;
    slot_next.t   = sector_index;
    if (pend) begin
      slot_next.vld  = 1'b1;
      slot_next.last = 1'b1;
      slot_next.a    = pa;
      slot_next.b    = pb;
      slot_next.c    = pc;
    end else if (acc) begin
      if (!func) begin
        slot_next.vld  = v_ok;
        slot_next.vtx  = 1'b1;
        slot_next.last = 1'b1;
      end else if (up) begin
        slot_next.vld  = t_ok;
        slot_next.last = !lo;
        slot_next.a    = cur[IDX_W-1:0];
        slot_next.b    = nxt[IDX_W-1:0];
        slot_next.c    = 17'(cur + 20'd1);
      end else begin
        slot_next.vld  = t_ok;
        slot_next.last = 1'b1;
        slot_next.a    = 17'(cur + 20'd1);
        slot_next.b    = nxt[IDX_W-1:0];
        slot_next.c    = 17'(nxt + 20'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      slot.vld <= 1'b0;
    end else begin
      pend     <= acc && func && t_ok && up && lo;
      slot.vld <= slot_next.vld;
    end
    slot.vtx  <= slot_next.vtx;
    slot.last <= slot_next.last;
    slot.s    <= slot_next.s;
    slot.t    <= slot_next.t;
    slot.a    <= slot_next.a;
    slot.b    <= slot_next.b;
    slot.c    <= slot_next.c;
    // lower triangle held for the following cycle
    pa <= 17'(cur + 20'd1);
    pb <= nxt[IDX_W-1:0];
    pc <= 17'(nxt + 20'd1);
  end

endmodule

@@ rtl/uvs_div.sv @@
// uvs_div: pipelined restoring divider, one quotient bit per stage. Uses uvs_pkg.
// The user must keep the divisor static while items are in flight; the divider does not enforce it.
`timescale 1ns / 1ps
module uvs_div import uvs_pkg::*; (
  input  logic             clk,
  input  logic [DIV_W-1:0] num,
  input  logic [CNT_W-1:0] den,
  output logic [DIV_W-1:0] quo
);

  logic [CNT_W-1:0] rem_q [DIV_W];
  logic [DIV_W-1:0] num_q [DIV_W];
  logic [DIV_W-1:0] quo_q [DIV_W];

  genvar k;
  generate
    for (k = 0; k < DIV_W; k++) begin : g_stage
      logic [CNT_W-1:0] rem_in;
      logic [DIV_W-1:0] num_in, quo_in;
      logic [CNT_W:0]   trial, diff;
      logic             ge;
      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign num_in = num;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[k-1];
        assign num_in = num_q[k-1];
        assign quo_in = quo_q[k-1];
      end
      assign trial = {rem_in, num_in[DIV_W-1]};
      assign ge    = trial >= {1'b0, den};
      assign diff  = trial - {1'b0, den};
      always_ff @(posedge clk) begin
        rem_q[k] <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        num_q[k] <= {num_in[DIV_W-2:0], 1'b0};
        quo_q[k] <= {quo_in[DIV_W-2:0], ge};
      end
    end
  endgenerate

  assign quo = quo_q[DIV_W-1];

endmodule

@@ rtl/uvs_cordic.sv @@
// uvs_cordic: pipelined rotation CORDIC, one stage per step, with the
// quadrant folded and rounded to Q1.14 in a last stage. Uses uvs_pkg.
`timescale 1ns / 1ps
module uvs_cordic import uvs_pkg::*; (
  input  logic                     clk,
  input  logic [31:0]              phase,
  output logic signed [UNIT_W-1:0] cos_o,
  output logic signed [UNIT_W-1:0] sin_o
);

  logic signed [CRD_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CRD_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [CRD_W-1:0] z_q [CORDIC_STEPS+1];
  logic [1:0]              qd_q [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    x_q[0]  <= CORDIC_GAIN;
    y_q[0]  <= '0;
    z_q[0]  <= $signed({3'b000, phase[29:0]});
    qd_q[0] <= phase[31:30];
  end

  genvar k;
  generate
    for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [CRD_W-1:0] dx, dy, at;
      assign dx = y_q[k] >>> k;
      assign dy = x_q[k] >>> k;
      assign at = $signed({1'b0, ATAN_TURNS[k]});
      always_ff @(posedge clk) begin
        if (z_q[k] >= 0) begin
          x_q[k+1] <= x_q[k] - dx;
          y_q[k+1] <= y_q[k] + dy;
          z_q[k+1] <= z_q[k] - at;
        end else begin
          x_q[k+1] <= x_q[k] + dx;
          y_q[k+1] <= y_q[k] - dy;
          z_q[k+1] <= z_q[k] + at;
        end
        qd_q[k+1] <= qd_q[k];
      end
    end
  endgenerate

  logic signed [CRD_W-1:0] xr, yr;
  logic signed [16:0]      xs, ys, cq, sq;

  assign xr = (x_q[CORDIC_STEPS] + 33'sd32768) >>> 16;
  assign yr = (y_q[CORDIC_STEPS] + 33'sd32768) >>> 16;
  assign xs = xr[16:0];
  assign ys = yr[16:0];
  assign cq = (xs > ONE_Q14) ? ONE_Q14 : ((xs < -ONE_Q14) ? -ONE_Q14 : xs);
  assign sq = (ys > ONE_Q14) ? ONE_Q14 : ((ys < -ONE_Q14) ? -ONE_Q14 : ys);

  always_ff @(posedge clk) begin
    case (qd_q[CORDIC_STEPS])
      2'd0: begin
        cos_o <= cq[UNIT_W-1:0];
        sin_o <= sq[UNIT_W-1:0];
      end
      2'd1: begin
        cos_o <= 16'(-sq);
        sin_o <= cq[UNIT_W-1:0];
      end
      2'd2: begin
        cos_o <= 16'(-cq);
        sin_o <= 16'(-sq);
      end
      default: begin
        cos_o <= sq[UNIT_W-1:0];
        sin_o <= 16'(-cq);
      end
    endcase
  end

endmodule

@@ rtl/uv_sphere_tessellator.sv @@
// uv_sphere_tessellator: top level. Intake, two dividers, two CORDICs,
// scaling and output register. Uses uvs_pkg, uvs_front, uvs_div, uvs_cordic.
//
//  channel  | signals                                   | beat taken when
//  ---------+-------------------------------------------+----------------------------
//  command  | start, busy, func, stack_index,           | start && !busy
//           | sector_index                              |
//  result   | result_valid, pos_*, norm_*, tex_*,       | every cycle result_valid
//           | tri_a/b/c, last                           | is high (no backpressure)
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// From command beat to result: intake register, 41 divider stages, 26
// CORDIC stages, 3 scaling stages. Throughput is one result per cycle:
// vertex queries and one-triangle queries can be issued every cycle; a
// two-triangle query holds busy for one extra cycle while the front end
// issues its second slot. Reset clears valid bits and config registers
// (radius 1.0, 36 sectors, 18 stacks). The receiver cannot stall, so the
// pipe never stops.
`timescale 1ns / 1ps
module uv_sphere_tessellator import uvs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // command
  input  logic                     start,
  output logic                     busy,
  input  logic                     func,
  input  logic [CNT_W-1:0]         stack_index,
  input  logic [CNT_W-1:0]         sector_index,
  // results
  output logic                     result_valid,
  output logic signed [16:0]       pos_x,
  output logic signed [16:0]       pos_y,
  output logic signed [16:0]       pos_z,
  output logic signed [15:0]       norm_x,
  output logic signed [15:0]       norm_y,
  output logic signed [15:0]       norm_z,
  output logic [16:0]              tex_u,
  output logic [16:0]              tex_v,
  output logic [IDX_W-1:0]         tri_a,
  output logic [IDX_W-1:0]         tri_b,
  output logic [IDX_W-1:0]         tri_c,
  output logic                     last,
  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  // sideband depth: lines up with the last scaling stage
  localparam int SB_D  = DIV_W + 28;
  localparam int TEX_D = 28;

  // ---- configuration registers ----
  logic [15:0]      radius;
  logic [CNT_W-1:0] sector_count, stack_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= 16'd256;
      sector_count <= 9'd36;
      stack_count  <= 9'd18;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIUS: radius       <= cfg_data;
        REG_SECTOR: sector_count <= cfg_data[CNT_W-1:0];
        REG_STACK:  stack_count  <= cfg_data[CNT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // counts clamped to the legal range
  logic [CNT_W-1:0] nsec, nstk;

  always_comb begin
    if (sector_count < 9'd3)                    nsec = 9'd3;
    else if (32'(sector_count) > MAX_SECTORS)   nsec = 9'(MAX_SECTORS);
    else                                        nsec = sector_count;
    if (stack_count < 9'd2)                     nstk = 9'd2;
    else if (32'(stack_count) > MAX_STACKS)     nstk = 9'(MAX_STACKS);
    else                                        nstk = stack_count;
  end

  // ---- intake ----
  slot_t slot;

  uvs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .stack_index  (stack_index),
    .sector_index (sector_index),
    .nsec         (nsec),
    .nstk         (nstk),
    .slot         (slot)
  );

  // ---- phases: round(t*2^32/nsec), round(s*2^31/nstk) ----
  logic [DIV_W-1:0] num_phi, num_th, quo_phi, quo_th;

  assign num_phi = {slot.t, 32'h0} + {33'h0, nsec[CNT_W-1:1]};
  assign num_th  = {1'b0, slot.s, 31'h0} + {33'h0, nstk[CNT_W-1:1]};

  uvs_div u_div_phi (.clk(clk), .num(num_phi), .den(nsec), .quo(quo_phi));
  uvs_div u_div_th  (.clk(clk), .num(num_th),  .den(nstk), .quo(quo_th));

  // texcoords come straight from the phases; the exact ratio never sits
  // on a half step, so rounding the phase gives the same answer
  logic [32:0] u_sum;
  logic [31:0] v_sum;
  logic [16:0] tu_line [TEX_D];
  logic [16:0] tv_line [TEX_D];

  assign u_sum = quo_phi[32:0] + 33'd32768;
  assign v_sum = quo_th[31:0] + 32'd16384;

  always_ff @(posedge clk) begin
    tu_line[0] <= u_sum[32:16];
    tv_line[0] <= v_sum[31:15];
    for (int i = 1; i < TEX_D; i++) begin
      tu_line[i] <= tu_line[i-1];
      tv_line[i] <= tv_line[i-1];
    end
  end

  // ---- sine / cosine ----
  logic signed [UNIT_W-1:0] ct, st, cp, sp;

  uvs_cordic u_crd_th  (.clk(clk), .phase(quo_th[31:0]),  .cos_o(ct), .sin_o(st));
  uvs_cordic u_crd_phi (.clk(clk), .phase(quo_phi[31:0]), .cos_o(cp), .sin_o(sp));

  // ---- scaling ----
  // stage 2: unit products and radius * cos(theta)
  logic signed [31:0] p_x, p_y;
  logic signed [32:0] p_z;
  logic signed [15:0] ct_d;

  always_ff @(posedge clk) begin
    p_x  <= st * cp;
    p_y  <= st * sp;
    p_z  <= $signed({1'b0, radius}) * ct;
    ct_d <= ct;
  end

  // stage 3: normals, z position, radius times unit products
  logic signed [48:0] r_x, r_y;
  logic signed [31:0] nx_w, ny_w;
  logic signed [32:0] pz_w;
  logic signed [15:0] n_x, n_y, n_z;
  logic signed [16:0] q_z;

  assign nx_w = (p_x + 32'sd8192) >>> 14;
  assign ny_w = (p_y + 32'sd8192) >>> 14;
  assign pz_w = (p_z + 33'sd8192) >>> 14;

  always_ff @(posedge clk) begin
    r_x <= $signed({1'b0, radius}) * p_x;
    r_y <= $signed({1'b0, radius}) * p_y;
    n_x <= nx_w[15:0];
    n_y <= ny_w[15:0];
    n_z <= ct_d;
    q_z <= pz_w[16:0];
  end

  // ---- sideband line ----
  side_t sb_line [SB_D];
  side_t sb_in, sb;

  assign sb_in = '{vld: slot.vld, vtx: slot.vtx, last: slot.last,
                   a: slot.a, b: slot.b, c: slot.c};
  assign sb    = sb_line[SB_D-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SB_D; i++) sb_line[i].vld <= 1'b0;
    end else begin
      sb_line[0].vld <= sb_in.vld;
      for (int i = 1; i < SB_D; i++) sb_line[i].vld <= sb_line[i-1].vld;
    end
    sb_line[0].vtx  <= sb_in.vtx;
    sb_line[0].last <= sb_in.last;
    sb_line[0].a    <= sb_in.a;
    sb_line[0].b    <= sb_in.b;
    sb_line[0].c    <= sb_in.c;
    for (int i = 1; i < SB_D; i++) begin
      sb_line[i].vtx  <= sb_line[i-1].vtx;
      sb_line[i].last <= sb_line[i-1].last;
      sb_line[i].a    <= sb_line[i-1].a;
      sb_line[i].b    <= sb_line[i-1].b;
      sb_line[i].c    <= sb_line[i-1].c;
    end
  end

  // ---- output register ----
  logic signed [48:0] px_w, py_w;

  assign px_w = (r_x + 49'sd134217728) >>> 28;
  assign py_w = (r_y + 49'sd134217728) >>> 28;

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= sb.vld;
    last  <= sb.last;
    tri_a <= sb.a;   // zero on vertex slots from the front end
    tri_b <= sb.b;
    tri_c <= sb.c;
    if (sb.vtx) begin
      pos_x  <= px_w[16:0];
      pos_y  <= py_w[16:0];
      pos_z  <= q_z;
      norm_x <= n_x;
      norm_y <= n_y;
      norm_z <= n_z;
      tex_u  <= tu_line[TEX_D-1];
      tex_v  <= tv_line[TEX_D-1];
    end else begin
      pos_x  <= '0;
      pos_y  <= '0;
      pos_z  <= '0;
      norm_x <= '0;
      norm_y <= '0;
      norm_z <= '0;
      tex_u  <= '0;
      tex_v  <= '0;
    end
  end

`ifndef SYNTHESIS
  // busy only follows an accepted command
  a_busy_cause : assert property (@(posedge clk) disable iff (rst)
    busy |-> ($past(start) && !$past(busy)))
    else $error("busy without a preceding command beat");

  // a split query holds off intake for exactly one cycle
  a_busy_single : assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // the first of two triangles is followed at once by the second
  a_pair_adjacent : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |=> (result_valid && last))
    else $error("triangle pair not delivered back to back");
`endif

endmodule
